// ----- hw/rtl/integer_to_radix_digits_macros.svh -----
// assertion macros for the integer to radix digits block
// used by the top level only; no other dependencies
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// same-cycle implication under the asynchronous reset
`define ITRD_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("itrd check failed: same cycle");

// next-cycle implication under the asynchronous reset
`define ITRD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("itrd check failed: next cycle");

`endif

// ----- hw/rtl/itrd_pkg.sv -----
// shared constants and helpers for the integer to radix digits block
// no dependencies
`timescale 1ns / 1ps

package itrd_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int NUMBER_W       = 64;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 6;
	localparam int STORE_DEPTH    = 64;
	localparam int IDX_W          = 6;
	localparam int CNT_W          = 7;
	localparam int GROUP_BITS     = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'd48;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0]  char_t;

	// clamp the radix into the supported range
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// digit to ascii, letters wrap modulo 256
	function automatic char_t digit_to_char(input digit_t d, input char_t letter);
		char_t res;
		if (d < DIGIT_TEN) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = letter + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/itrd_value_if.sv -----
// input channel: value, radix and letter code of one item
// depends on itrd_pkg
`timescale 1ns / 1ps

interface itrd_value_if;
	logic                            valid;
	logic                            ready;
	logic [itrd_pkg::NUMBER_W-1:0]   number;
	logic [itrd_pkg::RADIX_W-1:0]    radix;
	logic [itrd_pkg::CHAR_W-1:0]     letter_start;

	modport source (output valid, output number, output radix, output letter_start,
		input ready);
	modport sink (input valid, input number, input radix, input letter_start,
		output ready);
endinterface

// ----- hw/rtl/itrd_digit_if.sv -----
// output channel: one ascii digit and its last flag per item
// depends on itrd_pkg
`timescale 1ns / 1ps

interface itrd_digit_if;
	logic                        valid;
	logic                        ready;
	logic [itrd_pkg::CHAR_W-1:0] digit_char;
	logic                        last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- hw/rtl/integer_to_radix_digits.sv -----
// Converts an unsigned value into ASCII digits of a radix from 2 to 36, most significant
// digit first, one output item per digit with the last flag on the least significant one.
// Radix values below 2 or above 36 are clamped; bits of number above VALUE_BITS are
// ignored; a zero value gives the single digit '0'. One item is handled at a time and
// value_ch.ready is low until its last digit has been taken. A shared restoring divider
// retires 8 quotient bits per cycle; each digit is one pass of the divider over the value
// and then a write of the remainder to the 64-entry digit store. The digits are then read
// back from the store one at a time and presented; the sink may stall each of them.
// depends on itrd_pkg, itrd_value_if, itrd_digit_if, integer_to_radix_digits_macros.svh
`timescale 1ns / 1ps
`include "integer_to_radix_digits_macros.svh"

module integer_to_radix_digits #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	itrd_value_if.sink    value_ch,
	itrd_digit_if.source  digit_ch
);

	localparam int GB      = itrd_pkg::GROUP_BITS;
	localparam int STEPS   = (VALUE_BITS + GB - 1) / GB;
	localparam int PAD_W   = STEPS * GB;
	localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int RW      = itrd_pkg::RADIX_W;
	localparam int IW      = itrd_pkg::IDX_W;
	localparam int CW      = itrd_pkg::CNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_WB   = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]                 state_q;
	logic [PAD_W-1:0]           quo_q;
	logic [RW-1:0]              rem_q;
	logic [RW-1:0]              radix_q;
	itrd_pkg::char_t            letter_q;
	logic [STEP_W-1:0]          step_q;
	logic [CW-1:0]              cnt_q;
	logic [IW-1:0]              emit_idx_q;
	itrd_pkg::digit_t           rd_q;
	itrd_pkg::digit_t           store_q [itrd_pkg::STORE_DEPTH];

	logic [PAD_W-1:0]           quo_next;
	logic [RW-1:0]              rem_next;
	logic [GB-1:0]              qbits;
	logic [RW:0]                part;

	logic                       in_acc;
	logic                       out_acc;
	logic                       last_grp;
	logic                       done_div;

	assign in_acc   = value_ch.valid && value_ch.ready;
	assign out_acc  = digit_ch.valid && digit_ch.ready;
	assign last_grp = (step_q == STEP_W'(STEPS - 1));
	assign done_div = (quo_q == '0) || (cnt_q == CW'(itrd_pkg::STORE_DEPTH - 1));

	// shared divider: eight restoring steps on the 7-bit partial remainder
	always_comb begin
		part  = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < GB; i++) begin
			part = {part[RW-1:0], quo_q[PAD_W-1-i]};
			if (part >= {1'b0, radix_q}) begin
				part         = part - {1'b0, radix_q};
				qbits[GB-1-i] = 1'b1;
			end
		end
		rem_next = part[RW-1:0];
		quo_next = (quo_q << GB) | PAD_W'(qbits);
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			cnt_q      <= '0;
			emit_idx_q <= '0;
			quo_q      <= '0;
			rem_q      <= '0;
			radix_q    <= itrd_pkg::RADIX_MIN;
			letter_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						quo_q    <= PAD_W'(value_ch.number[VALUE_BITS-1:0]);
						rem_q    <= '0;
						radix_q  <= itrd_pkg::clamp_radix(value_ch.radix);
						letter_q <= value_ch.letter_start;
						step_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q  <= quo_next;
					rem_q  <= rem_next;
					step_q <= step_q + STEP_W'(1);
					if (last_grp) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					cnt_q <= cnt_q + CW'(1);
					if (done_div) begin
						emit_idx_q <= cnt_q[IW-1:0];
						state_q    <= S_RD;
					end else begin
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (emit_idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q - IW'(1);
							state_q    <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// digit store, written least significant first, read back in reverse
	always_ff @(posedge clk) begin
		if (state_q == S_WB) begin
			store_q[cnt_q[IW-1:0]] <= rem_q;
		end
		rd_q <= store_q[emit_idx_q];
	end

	// handshake and payload
	assign value_ch.ready      = (state_q == S_IDLE);
	assign digit_ch.valid      = (state_q == S_OUT);
	assign digit_ch.digit_char = itrd_pkg::digit_to_char(rd_q, letter_q);
	assign digit_ch.last_digit = (emit_idx_q == '0);

	// checks
	`ITRD_ASSERT_NOW(a_no_overlap, clk, arst_n, value_ch.ready, !digit_ch.valid)
	`ITRD_ASSERT_NEXT(a_last_frees_input, clk, arst_n, out_acc && digit_ch.last_digit, value_ch.ready)
	`ITRD_ASSERT_NEXT(a_start_clean, clk, arst_n, in_acc, (state_q == S_DIV) && (cnt_q == '0))
	`ITRD_ASSERT_NOW(a_radix_range, clk, arst_n, state_q != S_IDLE, (radix_q >= itrd_pkg::RADIX_MIN) && (radix_q <= itrd_pkg::RADIX_MAX))

endmodule

// ----- sim/integer_to_radix_digits_tb.sv -----
// testbench for integer_to_radix_digits: random and directed values, radixes and letter codes,
// expected digit strings built by a scoreboard class and compared item by item
// depends on itrd_pkg, itrd_value_if, itrd_digit_if and the integer_to_radix_digits rtl
`timescale 1ns / 1ps

module integer_to_radix_digits_tb;

	localparam int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF;
	localparam int MAX_GAP    = 17;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 345;

	typedef logic [itrd_pkg::NUMBER_W-1:0] number_t;
	typedef logic [itrd_pkg::RADIX_W-1:0]  radix_t;
	typedef itrd_pkg::char_t               char_t;

	typedef struct packed {
		char_t ch;
		logic  last;
	} digit_item_t;

	// expected digit strings, oldest first
	class digit_scoreboard;
		digit_item_t expected_digits[$];
		int          mismatches;
		int          items_taken;

		function new();
			mismatches  = 0;
			items_taken = 0;
		endfunction

		// expand one accepted value into its ascii digits, most significant first
		function void note_value(number_t number, radix_t radix, char_t letter);
			number_t     quotient;
			number_t     mask;
			radix_t      base;
			logic [5:0]  remainders[$];
			digit_item_t item;
			mask = {itrd_pkg::NUMBER_W{1'b1}} >> (itrd_pkg::NUMBER_W - VALUE_BITS);
			base = radix;
			if (base < 6'd2) begin
				base = 6'd2;
			end else if (base > 6'd36) begin
				base = 6'd36;
			end
			quotient = number & mask;
			do begin
				remainders.push_back(6'(quotient % number_t'(base)));
				quotient = quotient / number_t'(base);
			end while (quotient != 0 && remainders.size() < itrd_pkg::STORE_DEPTH);
			for (int k = remainders.size() - 1; k >= 0; k--) begin
				if (remainders[k] < 6'd10) begin
					item.ch = 8'd48 + 8'(remainders[k]);
				end else begin
					item.ch = letter + 8'(remainders[k]) - 8'd10;
				end
				item.last = (k == 0);
				expected_digits.push_back(item);
			end
			items_taken++;
		endfunction

		// compare one output digit with the oldest expected one
		function void check_digit(char_t ch, logic last);
			digit_item_t want;
			if (expected_digits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected digit: char %0d last %0b", ch, last);
				end
				return;
			end
			want = expected_digits.pop_front();
			if (want.ch !== ch || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("digit mismatch: expected char %0d last %0b, got char %0d last %0b",
						want.ch, want.last, ch, last);
				end
			end
		endfunction

		function int outstanding();
			return expected_digits.size();
		endfunction

		function bit clean();
			return mismatches == 0 && expected_digits.size() == 0;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic hold_off;

	itrd_value_if value_ch ();
	itrd_digit_if digit_ch ();

	digit_scoreboard sb;

	integer_to_radix_digits dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch),
		.digit_ch (digit_ch)
	);

	// clock and reset
	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// offer one value item after a random gap, return once it is accepted
	bit send_burst;

	task automatic send_value(number_t number, radix_t radix, char_t letter);
		int gap;
		if ($urandom_range(0, 7) == 0) begin
			send_burst = !send_burst;
		end
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			value_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		value_ch.valid        <= 1'b1;
		value_ch.number       <= number;
		value_ch.radix        <= radix;
		value_ch.letter_start <= letter;
		do @(posedge clk); while (!value_ch.ready);
		sb.note_value(number, radix, letter);
	endtask

	// random value with a random bit length so digit counts spread out
	task automatic send_random_values(int count);
		number_t number;
		radix_t  radix;
		char_t   letter;
		repeat (count) begin
			number = {$urandom(), $urandom()};
			if ($urandom_range(0, 9) != 0) begin
				number = number >> $urandom_range(0, 64);
			end
			if ($urandom_range(0, 6) == 0) begin
				radix = radix_t'($urandom_range(0, 63));
			end else begin
				radix = radix_t'($urandom_range(2, 36));
			end
			case ($urandom_range(0, 3))
				0: letter = 8'd97;
				1: letter = 8'd65;
				default: letter = char_t'($urandom_range(0, 255));
			endcase
			send_value(number, radix, letter);
		end
	endtask

	// digit sink with random stalls and the long hold-off
	initial begin
		bit burst;
		int gap;
		burst = 1'b0;
		digit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				burst = !burst;
			end
			gap = burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0 || hold_off) begin
				digit_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (hold_off) @(posedge clk);
			end
			digit_ch.ready <= 1'b1;
			do @(posedge clk); while (!digit_ch.valid);
			sb.check_digit(digit_ch.digit_char, digit_ch.last_digit);
		end
	end

	// one long receiver stall while values keep being offered
	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		while (sb.items_taken < 60) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// main sequence
	initial begin
		sb = new();
		send_burst            = 1'b0;
		value_ch.valid        <= 1'b0;
		value_ch.number       <= '0;
		value_ch.radix        <= '0;
		value_ch.letter_start <= '0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: zero, extremes, radix clamping, letter codes and wrap
		send_value(64'd0, 6'd10, 8'd97);
		send_value(64'd0, 6'd36, 8'd65);
		send_value({64{1'b1}}, 6'd2, 8'd97);
		send_value({64{1'b1}}, 6'd36, 8'd97);
		send_value({64{1'b1}}, 6'd10, 8'd65);
		send_value(64'h8000_0000_0000_0000, 6'd16, 8'd65);
		send_value(64'd1, 6'd2, 8'd97);
		send_value(64'd255, 6'd0, 8'd97);
		send_value(64'd255, 6'd1, 8'd97);
		send_value(64'd1295, 6'd37, 8'd97);
		send_value(64'd1295, 6'd63, 8'd65);
		send_value(64'hdead_beef_cafe_f00d, 6'd16, 8'd97);
		send_value(64'hdead_beef_cafe_f00d, 6'd16, 8'd65);
		send_value(64'd35, 6'd36, 8'd250);
		send_value(64'd1295, 6'd36, 8'd255);
		send_value(64'd10, 6'd36, 8'd0);
		send_value(64'd10, 6'd11, 8'd128);
		send_value(64'd10_000_000_000_000_000_000, 6'd10, 8'd97);
		send_value(64'o1234567, 6'd8, 8'd97);
		send_value(64'h5555_5555_5555_5555, 6'd3, 8'd97);
		send_value(64'haaaa_aaaa_aaaa_aaaa, 6'd35, 8'd170);
		send_value(64'd9, 6'd10, 8'd85);

		send_random_values(RANDOM_ITEMS);
		value_ch.valid <= 1'b0;

		// drain, then let the block settle
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.clean()) begin
			$display("integer_to_radix_digits_tb: PASS");
		end else begin
			$display("integer_to_radix_digits_tb: FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("integer_to_radix_digits_tb: FAIL");
		$finish;
	end

endmodule
